// File: hdl/csvt_pkg.sv
// shared types and character constants for the csv record tokenizer
package csvt_pkg;

  // character codes
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // input operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // configuration register indexes
  localparam logic CFG_DELIM_TAB = 1'b0;
  localparam logic CFG_DQ_ONLY   = 1'b1;

  // parser mode
  typedef enum logic [2:0] {
    M_REC_START  = 3'd0,
    M_FLD_START  = 3'd1,
    M_UNQUOTED   = 3'd2,
    M_QUOTED     = 3'd3,
    M_QUOTE_SEEN = 3'd4,
    M_DISCARD    = 3'd5,
    M_AFTER_CR   = 3'd6
  } mode_t;

  // result kinds
  typedef enum logic [1:0] {
    K_BYTE   = 2'd0,
    K_FIELD  = 2'd1,
    K_RECORD = 2'd2,
    K_ERROR  = 2'd3
  } kind_t;

endpackage

// File: hdl/csv_record_tokenizer.sv
// Byte-serial CSV tokenizer: one byte or end-of-input mark per transfer, at most one result
// each. Items pass through an input register, a combinational decode against the 3-bit parse
// mode, and a result register, so one item is taken every cycle while the result register
// is not stalled. The parse mode register updates once per accepted item, which sets the rate.
// A stalled result register stalls the input register but items that give no result still
// drain when the output is free. Configuration (delimiter, quote set) is to be written only
// while the block is idle; the block itself does not enforce this.
module csv_record_tokenizer
  import csvt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_wdata,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [7:0] in_data_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_field_byte
);

  // configuration registers
  logic delim_tab_r, dq_only_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_tab_r <= 1'b0;
      dq_only_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DELIM_TAB: delim_tab_r <= cfg_wdata;
        CFG_DQ_ONLY:   dq_only_r   <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // input register
  logic       s1_valid_r;
  logic       s1_op_r;
  logic [7:0] s1_byte_r;
  logic       s1_fire;

  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r   <= in_operation;
      s1_byte_r <= in_data_byte;
    end
  end

  // parse state
  mode_t mode_r, mode_nxt;
  logic  single_r, single_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  kind_t      kind_r;
  logic [7:0] fbyte_r;

  assign s1_fire = s1_valid_r && (!out_valid_r || out_ready);

  // character classes
  logic [7:0] delim_ch, quote_ch;
  logic       is_delim, is_cr, is_lf, is_eof_ch, opens_quote, close_quote;

  assign delim_ch    = delim_tab_r ? CH_TAB : CH_COMMA;
  assign quote_ch    = single_r ? CH_SQUOTE : CH_DQUOTE;
  assign is_delim    = (s1_byte_r == delim_ch);
  assign is_cr       = (s1_byte_r == CH_CR);
  assign is_lf       = (s1_byte_r == CH_LF);
  assign is_eof_ch   = is_delim || is_cr || is_lf;
  assign close_quote = (s1_byte_r == quote_ch);
  assign opens_quote = (s1_byte_r == CH_DQUOTE) || ((s1_byte_r == CH_SQUOTE) && !dq_only_r);

  // end-of-field decode, shared by several modes
  mode_t eof_mode;
  kind_t eof_kind;

  always_comb begin
    if (is_delim) begin
      eof_mode = M_FLD_START;
      eof_kind = K_FIELD;
    end else if (is_cr) begin
      eof_mode = M_AFTER_CR;
      eof_kind = K_RECORD;
    end else begin
      eof_mode = M_REC_START;
      eof_kind = K_RECORD;
    end
  end

  // field-start decode
  mode_t fs_mode;
  logic  fs_single, fs_res;
  kind_t fs_kind;

  always_comb begin
    fs_single = single_r;
    if (is_eof_ch) begin
      fs_mode = eof_mode;
      fs_res  = 1'b1;
      fs_kind = eof_kind;
    end else if (opens_quote) begin
      fs_mode   = M_QUOTED;
      fs_single = (s1_byte_r == CH_SQUOTE);
      fs_res    = 1'b0;
      fs_kind   = K_BYTE;
    end else begin
      fs_mode = M_UNQUOTED;
      fs_res  = 1'b1;
      fs_kind = K_BYTE;
    end
  end

  // next mode and result
  logic  res_valid;
  kind_t res_kind;

  always_comb begin
    mode_nxt   = mode_r;
    single_nxt = single_r;
    res_valid  = 1'b0;
    res_kind   = K_BYTE;
    if (s1_op_r == OP_END) begin
      mode_nxt = M_REC_START;
      unique case (mode_r) inside
        M_QUOTED: begin
          res_valid = 1'b1;
          res_kind  = K_ERROR;
        end
        M_FLD_START, M_UNQUOTED, M_QUOTE_SEEN, M_DISCARD: begin
          res_valid = 1'b1;
          res_kind  = K_RECORD;
        end
        default: ;
      endcase
    end else begin
      unique case (mode_r)
        M_UNQUOTED: begin
          res_valid = 1'b1;
          if (is_eof_ch) begin
            mode_nxt = eof_mode;
            res_kind = eof_kind;
          end
        end
        M_QUOTED: begin
          if (close_quote) begin
            mode_nxt = M_QUOTE_SEEN;
          end else begin
            res_valid = 1'b1;
          end
        end
        M_QUOTE_SEEN: begin
          if (close_quote) begin
            mode_nxt  = M_QUOTED;
            res_valid = 1'b1;
          end else if (is_eof_ch) begin
            mode_nxt  = eof_mode;
            res_valid = 1'b1;
            res_kind  = eof_kind;
          end else begin
            mode_nxt = M_DISCARD;
          end
        end
        M_DISCARD: begin
          if (is_eof_ch) begin
            mode_nxt  = eof_mode;
            res_valid = 1'b1;
            res_kind  = eof_kind;
          end
        end
        M_AFTER_CR: begin
          if (is_lf) begin
            mode_nxt = M_REC_START;
          end else begin
            mode_nxt   = fs_mode;
            single_nxt = fs_single;
            res_valid  = fs_res;
            res_kind   = fs_kind;
          end
        end
        default: begin
          mode_nxt   = fs_mode;
          single_nxt = fs_single;
          res_valid  = fs_res;
          res_kind   = fs_kind;
        end
      endcase
    end
  end

  // parse state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_REC_START;
      single_r <= 1'b0;
    end else if (s1_fire) begin
      mode_r   <= mode_nxt;
      single_r <= single_nxt;
    end
  end

  // result register
  always_comb begin
    if (s1_fire && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_valid) begin
      kind_r  <= res_kind;
      fbyte_r <= (res_kind == K_BYTE) ? s1_byte_r : 8'h00;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_field_byte  = fbyte_r;

`ifndef SYNTHESIS
  // non-byte results carry a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (kind_r != K_BYTE) |-> (fbyte_r == 8'h00))
    else $error("non-byte result with nonzero byte");

  // end of input always returns the parser to record start
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_op_r == OP_END) |=> (mode_r == M_REC_START))
    else $error("end of input left parser outside record start");

  // a record end caused by CR arms the LF swallow
  a_cr_mode: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_op_r == OP_BYTE) && res_valid && (res_kind == K_RECORD) && is_cr
    |=> (mode_r == M_AFTER_CR))
    else $error("record end on CR without after-CR mode");

  // an error result only follows an end of input in a quoted field
  a_error_src: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && res_valid && (res_kind == K_ERROR)
    |-> (s1_op_r == OP_END) && (mode_r == M_QUOTED))
    else $error("error result from wrong state");
`endif

endmodule
